// File: rtl/fmrs_pkg.sv
// Shared constants and types for the FM register shadow block.
`default_nettype none
package fmrs_pkg;

   localparam int CHANNELS      = 18;
   localparam int BANK_CHANNELS = CHANNELS / 2;
   localparam int OP_FIELDS     = 10;
   localparam int CH_FIELDS     = 3;
   localparam int OP_DEPTH      = CHANNELS * OP_FIELDS;
   localparam int CH_DEPTH      = CHANNELS * CH_FIELDS;
   localparam int CHAN_W        = $clog2(CHANNELS);
   localparam int OP_IDX_W      = $clog2(OP_DEPTH);
   localparam int CH_IDX_W      = $clog2(CH_DEPTH);

   // Register offsets of the chip-global registers
   localparam logic [7:0] REG_ENABLE  = 8'h01;
   localparam logic [7:0] REG_PAIR    = 8'h04;
   localparam logic [7:0] REG_NOTESEL = 8'h08;
   localparam logic [7:0] REG_RHYTHM  = 8'hBD;

   // High nibbles of the per-channel register groups
   localparam logic [3:0] GRP_FREQ_LO = 4'hA;
   localparam logic [3:0] GRP_KEY     = 4'hB;
   localparam logic [3:0] GRP_FEED    = 4'hC;

   // Channel shadow field within a channel row
   localparam logic [1:0] CHF_FEED    = 2'd0;
   localparam logic [1:0] CHF_FREQ_LO = 2'd1;
   localparam logic [1:0] CHF_KEY     = 2'd2;

   // Key-on bit within the key/block/fnum-high byte
   localparam int KEY_BIT = 5;

   // Result target codes
   localparam logic [4:0] TGT_NONE     = 5'd0;
   localparam logic [4:0] TGT_ENABLE   = 5'd1;
   localparam logic [4:0] TGT_PAIR     = 5'd2;
   localparam logic [4:0] TGT_NOTESEL  = 5'd3;
   localparam logic [4:0] TGT_RHYTHM   = 5'd4;
   localparam logic [4:0] TGT_OP_FIRST = 5'd5;
   localparam logic [4:0] TGT_FEED     = 5'd15;
   localparam logic [4:0] TGT_FREQ_LO  = 5'd16;
   localparam logic [4:0] TGT_KEY      = 5'd17;

   typedef struct packed {
      logic [4:0]          target;
      logic [CHAN_W-1:0]   channel;
      logic                op_we;
      logic                ch_we;
      logic [OP_IDX_W-1:0] op_idx;
      logic [CH_IDX_W-1:0] ch_idx;
   } decode_type;

endpackage
`default_nettype wire

// File: rtl/fmrs_decode.sv
// Offset decoder: bank/offset to target code, channel and shadow indexes.
`default_nettype none
module fmrs_decode (
   input  wire logic              bank,
   input  wire logic [7:0]        reg_offset,
   output fmrs_pkg::decode_type   dec
);
   import fmrs_pkg::*;

   logic              blk_hit;
   logic [2:0]        blk;
   logic [1:0]        grp;
   logic [2:0]        w;
   logic              opn;
   logic [3:0]        slot;
   logic [3:0]        low;
   logic [CHAN_W-1:0] base;
   logic [CHAN_W-1:0] chan;
   logic [1:0]        field;

   always_comb begin
      grp   = reg_offset[4:3];
      w     = reg_offset[2:0];
      opn   = (w >= 3'd3);
      low   = reg_offset[3:0];
      base  = bank ? CHAN_W'(BANK_CHANNELS) : '0;
      chan  = '0;
      field = CHF_FEED;
      dec   = '0;

      // operator register blocks 0x20, 0x40, 0x60, 0x80, 0xE0
      blk_hit = 1'b1;
      unique case (reg_offset[7:5])
         3'd1:    blk = 3'd0;
         3'd2:    blk = 3'd1;
         3'd3:    blk = 3'd2;
         3'd4:    blk = 3'd3;
         3'd7:    blk = 3'd4;
         default: begin
            blk     = 3'd0;
            blk_hit = 1'b0;
         end
      endcase
      slot = 4'({blk, 1'b0}) + 4'(opn);

      if (reg_offset == REG_ENABLE) begin
         dec.target = TGT_ENABLE;
      end else if (reg_offset == REG_PAIR) begin
         if (bank) begin
            dec.target = TGT_PAIR;
         end
      end else if (reg_offset == REG_NOTESEL) begin
         dec.target = TGT_NOTESEL;
      end else if (reg_offset == REG_RHYTHM) begin
         dec.target = TGT_RHYTHM;
      end else if (blk_hit) begin
         // slots 6,7 of each group and anything past slot 21 are gaps
         if (reg_offset[4:0] <= 5'd21 && w <= 3'd5) begin
            chan = base + CHAN_W'({grp, 1'b0}) + CHAN_W'(grp)
                 + CHAN_W'(opn ? (w - 3'd3) : w);
            dec.target = TGT_OP_FIRST + 5'(slot);
            dec.op_we  = 1'b1;
         end
      end else if (low <= 4'd8) begin
         if (reg_offset[7:4] == GRP_FEED) begin
            chan       = base + CHAN_W'(low);
            dec.target = TGT_FEED;
            dec.ch_we  = 1'b1;
            field      = CHF_FEED;
         end else if (reg_offset[7:4] == GRP_FREQ_LO) begin
            chan       = base + CHAN_W'(low);
            dec.target = TGT_FREQ_LO;
            dec.ch_we  = 1'b1;
            field      = CHF_FREQ_LO;
         end else if (reg_offset[7:4] == GRP_KEY) begin
            chan       = base + CHAN_W'(low);
            dec.target = TGT_KEY;
            dec.ch_we  = 1'b1;
            field      = CHF_KEY;
         end
      end

      dec.channel = chan;
      // row * 10 and row * 3 as shift-adds
      dec.op_idx  = OP_IDX_W'({chan, 3'b000}) + OP_IDX_W'({chan, 1'b0}) + OP_IDX_W'(slot);
      dec.ch_idx  = CH_IDX_W'({chan, 1'b0}) + CH_IDX_W'(chan) + CH_IDX_W'(field);
   end

endmodule
`default_nettype wire

// File: rtl/fm_synth_register_shadow.sv
// Top level: write snooper and shadow store for a two-bank FM register map.
`default_nettype none
// Each beat on req_ is one snooped register write (bank, offset, byte); each
// produces exactly one beat on rsp_ carrying the decoded target code, the
// channel, and a flag that is set when a key/block/fnum-high write flips the
// channel's key-on bit (bit 5). Sustained rate is one beat per clock while
// rsp_ready is high; each beat is registered in stage 1 and then in the
// output register on rsp_. Stage 1 holds the beat while the channel shadow
// memory is read; that read gives the stored key byte for the key-on
// compare. A write to the same shadow entry in the next beat is forwarded,
// so back-to-back key writes compare correctly. Operator registers live in
// a 180-entry memory, per-channel registers in a 54-entry memory, the four
// global registers in flops. Reset needs no clearing pass: 18 per-channel
// valid bits make a key entry that was never written read as zero. The
// block is ready again in the cycle after reset is released.
module fm_synth_register_shadow (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_bank,
   input  wire logic [7:0] req_reg_offset,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_key_changed,
   output logic [4:0]      rsp_target,
   output logic [4:0]      rsp_channel
);
   import fmrs_pkg::*;

   // shadow memories
   logic [7:0] op_mem [OP_DEPTH];
   logic [7:0] ch_mem [CH_DEPTH];

   // global registers
   logic [7:0] chip_enable_ff;
   logic [7:0] pair_mask_ff;
   logic [7:0] note_select_ff;
   logic [7:0] rhythm_ff;

   // per-channel valid for the key entry
   logic [CHANNELS-1:0] key_valid_ff;

   decode_type dec;

   // stage 1: decoded beat while the memory read is in flight
   logic       s1_valid_ff;
   decode_type s1_dec_ff;
   logic [7:0] s1_data_ff;
   logic [7:0] ch_rd_ff;
   logic       fwd_ff;
   logic [7:0] fwd_data_ff;

   // output register
   logic       rsp_valid_ff;
   logic       rsp_key_changed_ff;
   logic [4:0] rsp_target_ff;
   logic [4:0] rsp_channel_ff;

   logic s1_adv;
   logic accept;
   logic old_key;
   logic key_changed;

   fmrs_decode u_decode (
      .bank       (req_bank),
      .reg_offset (req_reg_offset),
      .dec        (dec)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // stored key bit: forwarded from the write in flight, else memory, else zero
   always_comb begin
      if (fwd_ff) begin
         old_key = fwd_data_ff[KEY_BIT];
      end else if (key_valid_ff[s1_dec_ff.channel]) begin
         old_key = ch_rd_ff[KEY_BIT];
      end else begin
         old_key = 1'b0;
      end
      key_changed = (s1_dec_ff.target == TGT_KEY) && (old_key != s1_data_ff[KEY_BIT]);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_valid_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_adv && s1_dec_ff.target == TGT_KEY) begin
            key_valid_ff[s1_dec_ff.channel] <= 1'b1;
         end
      end
   end

   // global registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_enable_ff <= '0;
         pair_mask_ff   <= '0;
         note_select_ff <= '0;
         rhythm_ff      <= '0;
      end else if (s1_adv) begin
         if (s1_dec_ff.target == TGT_ENABLE) begin
            chip_enable_ff <= s1_data_ff;
         end
         if (s1_dec_ff.target == TGT_PAIR) begin
            pair_mask_ff <= s1_data_ff;
         end
         if (s1_dec_ff.target == TGT_NOTESEL) begin
            note_select_ff <= s1_data_ff;
         end
         if (s1_dec_ff.target == TGT_RHYTHM) begin
            rhythm_ff <= s1_data_ff;
         end
      end
   end

   // stage 1 payload, memory read and same-entry forward
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dec_ff   <= dec;
         s1_data_ff  <= req_data_byte;
         ch_rd_ff    <= ch_mem[dec.ch_idx];
         fwd_ff      <= s1_adv && s1_dec_ff.ch_we && (s1_dec_ff.ch_idx == dec.ch_idx);
         fwd_data_ff <= s1_data_ff;
      end
   end

   // memory write-back
   always_ff @(posedge clock) begin
      if (s1_adv && s1_dec_ff.ch_we) begin
         ch_mem[s1_dec_ff.ch_idx] <= s1_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_dec_ff.op_we) begin
         op_mem[s1_dec_ff.op_idx] <= s1_data_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_key_changed_ff <= key_changed;
         rsp_target_ff      <= s1_dec_ff.target;
         rsp_channel_ff     <= 5'(s1_dec_ff.channel);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_changed = rsp_key_changed_ff;
   assign rsp_target      = rsp_target_ff;
   assign rsp_channel     = rsp_channel_ff;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Testbench for fm_synth_register_shadow: write decode, key-on change flag, flow control.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fmrs_pkg::*;

   // Operator register blocks, selected by offset bits 7:5
   localparam logic [2:0] OPB_FLAGS   = 3'd1;
   localparam logic [2:0] OPB_LEVEL   = 3'd2;
   localparam logic [2:0] OPB_ATTACK  = 3'd3;
   localparam logic [2:0] OPB_SUSTAIN = 3'd4;
   localparam logic [2:0] OPB_WAVE    = 3'd7;

   localparam int OP_LAST_OFF  = 21;                // last decoded offset within a block
   localparam int OP_LAST_SLOT = 5;                 // slots 6 and 7 of a group are holes
   localparam int CH_LAST      = BANK_CHANNELS - 1; // per-channel offsets 0..8 only

   localparam int LONG_HOLD     = 150;  // forced receiver stall, in cycles
   localparam int HOLD_AT       = 300;  // results seen before the forced stall
   localparam int SETTLE_CYCLES = 20;   // quiet cycles at the end to catch strays

   // One write beat as queued for the driver. A drain entry is not a write:
   // it holds the sender until every expected result has come back.
   typedef struct {
      logic       bank;
      logic [7:0] offset;
      logic [7:0] data;
      int         gap;
      bit         drain;
   } write_beat_type;

   typedef struct {
      logic       key_changed;
      logic [4:0] target;
      logic [4:0] channel;
   } shadow_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_bank = 1'b0;
   logic [7:0] req_reg_offset = 8'h00;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_key_changed;
   logic [4:0] rsp_target;
   logic [4:0] rsp_channel;

   write_beat_type    pending_writes[$];
   shadow_result_type expected_results[$];

   // Only the key-on bits are visible at the result port; the byte shadows
   // never show up there, so the predictor tracks the key bits alone.
   logic key_state [CHANNELS];

   int gap_left = 0;
   int hold_left = 0;
   int results_seen = 0;
   int results_owed = 0;   // expected results outstanding, updated by NBA
   int mismatches = 0;
   int ready_roll;
   bit long_hold_done = 1'b0;

   fm_synth_register_shadow dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_bank        (req_bank),
      .req_reg_offset  (req_reg_offset),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_changed (rsp_key_changed),
      .rsp_target      (rsp_target),
      .rsp_channel     (rsp_channel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode one snooped write and update the key bits. Bank 1 shifts the
   // channel up by nine; the pairing register only lands in bank 1.
   function automatic shadow_result_type decode_write(logic bank, logic [7:0] offset,
                                                      logic [7:0] data);
      shadow_result_type res;
      int base;
      int blk;
      int d;
      int w;
      int opn;
      int ch;
      res = '{1'b0, TGT_NONE, 5'd0};
      base = bank ? BANK_CHANNELS : 0;
      case (offset[7:5])
         OPB_FLAGS:   blk = 0;
         OPB_LEVEL:   blk = 1;
         OPB_ATTACK:  blk = 2;
         OPB_SUSTAIN: blk = 3;
         OPB_WAVE:    blk = 4;
         default:     blk = -1;
      endcase
      if (offset == REG_ENABLE) begin
         res.target = TGT_ENABLE;
      end else if (offset == REG_PAIR) begin
         if (bank) res.target = TGT_PAIR;
      end else if (offset == REG_NOTESEL) begin
         res.target = TGT_NOTESEL;
      end else if (offset == REG_RHYTHM) begin
         res.target = TGT_RHYTHM;
      end else if (blk >= 0) begin
         d = int'(offset[4:0]);
         w = int'(offset[2:0]);
         if (d <= OP_LAST_OFF && w <= OP_LAST_SLOT) begin
            // slots 0..2 are operator 1 of three channels, 3..5 operator 2
            opn = (w >= 3) ? 1 : 0;
            ch = base + int'(offset[4:3]) * 3 + (w - opn * 3);
            res.target = TGT_OP_FIRST + 5'(blk * 2 + opn);
            res.channel = 5'(ch);
         end
      end else if (offset[3:0] <= CH_LAST && offset[7:4] == GRP_FEED) begin
         res.target = TGT_FEED;
         res.channel = 5'(base + int'(offset[3:0]));
      end else if (offset[3:0] <= CH_LAST && offset[7:4] == GRP_FREQ_LO) begin
         res.target = TGT_FREQ_LO;
         res.channel = 5'(base + int'(offset[3:0]));
      end else if (offset[3:0] <= CH_LAST && offset[7:4] == GRP_KEY) begin
         ch = base + int'(offset[3:0]);
         res.target = TGT_KEY;
         res.channel = 5'(ch);
         res.key_changed = (key_state[ch] != data[KEY_BIT]);
         key_state[ch] = data[KEY_BIT];
      end
      return res;
   endfunction

   task automatic add_write(logic bank, logic [7:0] offset, logic [7:0] data, int gap);
      pending_writes.push_back('{bank, offset, data, gap, 1'b0});
   endtask

   task automatic add_drain();
      pending_writes.push_back('{1'b0, 8'h00, 8'h00, 0, 1'b1});
   endtask

   function automatic logic [2:0] random_op_block();
      case ($urandom_range(0, 4))
         0:       return OPB_FLAGS;
         1:       return OPB_LEVEL;
         2:       return OPB_ATTACK;
         3:       return OPB_SUSTAIN;
         default: return OPB_WAVE;
      endcase
   endfunction

   // Mostly offsets that decode, weighted toward key writes so the key-on
   // flag flips often; the rest are near misses and plain noise.
   function automatic logic [7:0] random_offset();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         return {GRP_KEY, 4'($urandom_range(0, CH_LAST))};
      end else if (roll < 50) begin
         return {random_op_block(), 2'($urandom_range(0, 2)), 3'($urandom_range(0, 5))};
      end else if (roll < 60) begin
         return {($urandom_range(0, 1) ? GRP_FEED : GRP_FREQ_LO),
                 4'($urandom_range(0, CH_LAST))};
      end else if (roll < 68) begin
         case ($urandom_range(0, 3))
            0:       return REG_ENABLE;
            1:       return REG_PAIR;
            2:       return REG_NOTESEL;
            default: return REG_RHYTHM;
         endcase
      end else if (roll < 80) begin
         case ($urandom_range(0, 2))
            0:       return {random_op_block(), 2'($urandom_range(0, 3)),
                             3'($urandom_range(6, 7))};
            1:       return {random_op_block(), 5'($urandom_range(OP_LAST_OFF + 1, 31))};
            default: return {($urandom_range(0, 1) ? GRP_KEY : GRP_FEED),
                             4'($urandom_range(CH_LAST + 1, 15))};
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly back to back or short gaps, now and then a long one
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Driver: presents queued beats on req_, holding each until accepted.
   always @(posedge clock) begin : driver
      write_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (req_valid && !req_ready) begin
         // beat still waiting; payload stays put
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_writes.size() == 0) begin
         req_valid <= 1'b0;
      end else if (pending_writes[0].drain) begin
         // a beat taken at this edge is not yet in results_owed
         req_valid <= 1'b0;
         if (!(req_valid && req_ready) && results_owed == 0)
            void'(pending_writes.pop_front());
      end else if (pending_writes[0].gap > 0) begin
         req_valid <= 1'b0;
         gap_left <= pending_writes[0].gap - 1;
         pending_writes[0].gap = 0;
      end else begin
         beat = pending_writes.pop_front();
         req_valid <= 1'b1;
         req_bank <= beat.bank;
         req_reg_offset <= beat.offset;
         req_data_byte <= beat.data;
      end
   end

   // Receiver: random stalls, one forced long stall once a few hundred
   // results are in, and a window with no stalls at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
         long_hold_done <= 1'b1;
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
      end else if (results_seen >= 900 && results_seen < 1100) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 70) begin
            rsp_ready <= 1'b1;
         end else if (ready_roll < 95) begin
            rsp_ready <= 1'b0;
            hold_left <= $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b0;
            hold_left <= $urandom_range(10, 40);
         end
      end
   end

   // Monitor: predicts on every accepted write beat and checks every
   // accepted result beat against the oldest prediction.
   always @(posedge clock) begin : monitor
      shadow_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(decode_write(req_bank, req_reg_offset, req_data_byte));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: key_changed=%0d target=%0d channel=%0d",
                           rsp_key_changed, rsp_target, rsp_channel);
            end else begin
               want = expected_results.pop_front();
               if (rsp_key_changed !== want.key_changed || rsp_target !== want.target ||
                   rsp_channel !== want.channel) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected key_changed=%0d target=%0d channel=%0d,",
                               " got key_changed=%0d target=%0d channel=%0d"},
                              want.key_changed, want.target, want.channel,
                              rsp_key_changed, rsp_target, rsp_channel);
               end
            end
            results_seen <= results_seen + 1;
         end
         results_owed <= expected_results.size();
      end
   end

   initial begin
      foreach (key_state[i]) key_state[i] = 1'b0;

      // Directed: globals in both banks, pairing in bank 0 dropped
      add_write(1'b0, REG_ENABLE, 8'hFF, 0);
      add_write(1'b1, REG_ENABLE, 8'h00, 0);
      add_write(1'b0, REG_PAIR, 8'h3F, 0);
      add_write(1'b1, REG_PAIR, 8'hC0, 2);
      add_write(1'b1, REG_NOTESEL, 8'h40, 0);
      add_write(1'b0, REG_RHYTHM, 8'hDF, 0);
      // every operator block once, including the first and last decoded offset
      add_write(1'b0, {OPB_FLAGS, 5'd0}, 8'h01, 0);
      add_write(1'b1, {OPB_LEVEL, 5'd21}, 8'hFE, 0);
      add_write(1'b0, {OPB_ATTACK, 5'd11}, 8'h80, 1);
      add_write(1'b1, {OPB_SUSTAIN, 5'd8}, 8'h7F, 0);
      add_write(1'b0, {OPB_WAVE, 5'd4}, 8'h55, 0);
      // holes in the operator map
      add_write(1'b1, {OPB_FLAGS, 5'd6}, 8'hAA, 0);
      add_write(1'b0, {OPB_WAVE, 5'd15}, 8'h12, 0);
      add_write(1'b1, {OPB_LEVEL, 5'd22}, 8'h34, 0);
      // per-channel registers, in range and past channel 8
      add_write(1'b0, {GRP_FREQ_LO, 4'd0}, 8'hFF, 0);
      add_write(1'b1, {GRP_FEED, 4'd8}, 8'h0F, 0);
      add_write(1'b0, {GRP_FEED, 4'd9}, 8'h0F, 0);
      add_write(1'b1, {GRP_FREQ_LO, 4'd15}, 8'h00, 0);
      // back-to-back key writes on one channel: on, hold, off
      add_write(1'b0, {GRP_KEY, 4'd0}, 8'h20, 0);
      add_write(1'b0, {GRP_KEY, 4'd0}, 8'h3F, 0);
      add_write(1'b0, {GRP_KEY, 4'd0}, 8'h00, 0);
      add_write(1'b1, {GRP_KEY, 4'd8}, 8'hFF, 0);
      add_write(1'b1, {GRP_KEY, 4'd8}, 8'hDF, 3);
      // nothing decodes
      add_write(1'b0, 8'h00, 8'h55, 0);
      add_write(1'b1, 8'hFF, 8'hAA, 0);
      add_drain();

      // Random writes; zero gaps around the forced receiver stall so the
      // block backs up, drains at two points along the way
      for (int n = 0; n < 1450; n++) begin
         add_write(1'($urandom_range(0, 1)), random_offset(), 8'($urandom_range(0, 255)),
                   (n >= 250 && n < 450) ? 0 : random_gap());
         if (n == 500 || n == 1000) add_drain();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_writes.size() != 0 || req_valid || results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0)
         $display("fm_synth_register_shadow test passed");
      else
         $display("fm_synth_register_shadow test failed");
      $finish;
   end

   // Generous ceiling on the length of the run
   initial begin
      #5_000_000;
      $display("fm_synth_register_shadow test failed");
      $finish;
   end

endmodule
